### hdl/csm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants for the cron schedule matcher
// Rule encoding, time vector types and the step-divisibility table.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int NUM_FIELDS      = 5;
    localparam int VAL_W           = 6;
    localparam int DIV_W           = 64;   // one bit per possible step divisor

    // rule kinds
    localparam logic [1:0] KIND_NEVER = 2'd0;
    localparam logic [1:0] KIND_ANY   = 2'd1;
    localparam logic [1:0] KIND_EXACT = 2'd2;
    localparam logic [1:0] KIND_STEP  = 2'd3;

    // field indexes
    localparam logic [2:0] FLD_MINUTE  = 3'd0;
    localparam logic [2:0] FLD_WEEKDAY = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] value;
    } rule_t;

    typedef rule_t [NUM_FIELDS-1:0]            entry_t;
    typedef logic [NUM_FIELDS-1:0][VAL_W-1:0]  time_vec_t;
    typedef logic [NUM_FIELDS-1:0][DIV_W-1:0]  div_vec_t;
    typedef logic [DIV_W-1:0][DIV_W-1:0]       div_table_t;

    // row v: bit n set when n divides v (bit 0 stays clear: step of zero never hits)
    // built by marking every multiple of each divisor
    function automatic div_table_t build_div_table();
        div_table_t t;
        t = '0;
        for (int n = 1; n < DIV_W; n++) begin
            for (int m = 0; m < DIV_W; m += n) begin
                t[m][n] = 1'b1;
            end
        end
        return t;
    endfunction

    localparam div_table_t DIV_TABLE = build_div_table();

endpackage

### hdl/csm_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_rule_mem: schedule entry table
// One write port, one registered read port; per-entry valid bits make
// unwritten entries read as never-match after reset.
// ----------------------------------------------------------------------------
module csm_rule_mem #(
    parameter int DEPTH = csm_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  csm_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output csm_pkg::entry_t      rd_data
);
    import csm_pkg::*;

    entry_t             rule_mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // never-written entry: all kinds NEVER
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hdl/csm_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csm_match: entry rule evaluator
// Checks the five rules of one entry against the latched time.
// ----------------------------------------------------------------------------
module csm_match (
    input  csm_pkg::entry_t     rules,
    input  csm_pkg::time_vec_t  cur,
    input  csm_pkg::div_vec_t   dmask,
    output logic                hit
);
    import csm_pkg::*;

    logic [NUM_FIELDS-1:0] fld_ok;

    always_comb begin
        for (int f = 0; f < NUM_FIELDS; f++) begin
            case (rules[f].kind)
                KIND_NEVER: fld_ok[f] = 1'b0;
                KIND_ANY:   fld_ok[f] = 1'b1;
                KIND_EXACT: fld_ok[f] = (rules[f].value == cur[f]);
                KIND_STEP:  fld_ok[f] = dmask[f][rules[f].value];
                default:    fld_ok[f] = 1'b0;
            endcase
        end
    end

    assign hit = &fld_ok;

endmodule

### hdl/cron_schedule_matcher.sv
`timescale 1ns / 1ps
// A rule write reads its entry, then writes it back with one rule merged in, and
// gives no result. A time transfer with unchanged time goes straight to ST_DONE
// for its result; a changed time scans one entry per cycle, set by the single
// read port of the entry table. One item is in work at a time; s_tready is high
// while idle, even with a result still waiting on m_*. Reset (aresetn low,
// synchronous) clears the stored time to zero and marks every entry never-match.
// ----------------------------------------------------------------------------
// cron_schedule_matcher: cron-style alarm matcher
// Table of schedule entries with five field rules each; a time change scans
// the table in order and reports the first entry that matches.
// ----------------------------------------------------------------------------
module cron_schedule_matcher #(
    parameter int MAX_ENTRIES = csm_pkg::DEF_MAX_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] minute, [10:6] hour, [15:11] day, [19:16] month, [22:20] weekday,
    // [26:23] entry_select, [29:27] field_select, [31:30] rule_kind,
    // [37:32] rule_value, [39:38] zero
    input  logic [39:0] s_tdata,
    // [0] mode
    input  logic [0:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] fired_entry, [7:4] zero
    output logic [7:0]  m_tdata,
    // [0] time_changed, [1] fired
    output logic [1:0]  m_tuser
);
    import csm_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a transfer
    localparam logic [1:0] ST_WR   = 2'd1;   // merge one rule into the entry read
    localparam logic [1:0] ST_SCAN = 2'd2;   // evaluate entry idx, fetch idx+1
    localparam logic [1:0] ST_DONE = 2'd3;   // hand result to the output register

    logic [1:0]        state_reg, state_next;
    time_vec_t         cur_reg, cur_next;        // latched time, zero-extended
    div_vec_t          dmask_reg, dmask_next;    // divisor masks of latched time
    logic [22:0]       prev_reg, prev_next;      // previous time, packed
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [2:0]        wr_field_reg, wr_field_next;
    rule_t             wr_rule_reg, wr_rule_next;
    logic              res_changed_reg, res_changed_next;
    logic              res_fired_reg, res_fired_next;
    logic [3:0]        res_entry_reg, res_entry_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_user_reg, m_user_next;
    logic [3:0]        m_entry_reg, m_entry_next;

    // table port
    logic              tbl_wr_en;
    entry_t            tbl_wr_data;
    logic              tbl_rd_en;
    logic [IDX_W-1:0]  tbl_rd_addr;
    entry_t            tbl_rd_data;
    logic              entry_hit;

    // input unpacking
    logic              s_acc;
    time_vec_t         now_vec;
    logic [22:0]       now_bits;
    logic              now_changed;
    logic              wr_legal;
    logic [IDX_W-1:0]  sel_addr;
    rule_t             in_rule;

    assign s_acc    = s_tvalid && s_tready;
    assign now_bits = s_tdata[22:0];
    assign now_vec[0] = s_tdata[5:0];
    assign now_vec[1] = {1'b0, s_tdata[10:6]};
    assign now_vec[2] = {1'b0, s_tdata[15:11]};
    assign now_vec[3] = {2'b00, s_tdata[19:16]};
    assign now_vec[4] = {3'b000, s_tdata[22:20]};
    assign now_changed = (now_bits != prev_reg);

    // writes beyond the table or with an unknown field are dropped
    assign wr_legal = (32'(s_tdata[26:23]) < 32'(MAX_ENTRIES)) &&
                      (s_tdata[29:27] <= FLD_WEEKDAY);
    assign sel_addr      = IDX_W'(s_tdata[26:23]);
    assign in_rule.kind  = s_tdata[31:30];
    assign in_rule.value = s_tdata[37:32];

    assign s_tready = (state_reg == ST_IDLE);

    csm_rule_mem #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_rule_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    csm_match u_match (
        .rules (tbl_rd_data),
        .cur   (cur_reg),
        .dmask (dmask_reg),
        .hit   (entry_hit)
    );

    always_comb begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        dmask_next       = dmask_reg;
        prev_next        = prev_reg;
        idx_next         = idx_reg;
        wr_addr_next     = wr_addr_reg;
        wr_field_next    = wr_field_reg;
        wr_rule_next     = wr_rule_reg;
        res_changed_next = res_changed_reg;
        res_fired_next   = res_fired_reg;
        res_entry_next   = res_entry_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_user_next      = m_user_reg;
        m_entry_next     = m_entry_reg;

        tbl_rd_en   = 1'b0;
        tbl_rd_addr = idx_reg;
        tbl_wr_en   = 1'b0;
        // read-modify-write: replace one rule of the fetched entry
        tbl_wr_data = tbl_rd_data;
        tbl_wr_data[wr_field_reg] = wr_rule_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0]) begin
                        if (wr_legal) begin
                            wr_addr_next  = sel_addr;
                            wr_field_next = s_tdata[29:27];
                            wr_rule_next  = in_rule;
                            tbl_rd_en     = 1'b1;
                            tbl_rd_addr   = sel_addr;
                            state_next    = ST_WR;
                        end
                    end else if (now_changed) begin
                        cur_next  = now_vec;
                        prev_next = now_bits;
                        for (int f = 0; f < NUM_FIELDS; f++) begin
                            dmask_next[f] = DIV_TABLE[now_vec[f]];
                        end
                        idx_next    = '0;
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = '0;
                        state_next  = ST_SCAN;
                    end else begin
                        res_changed_next = 1'b0;
                        res_fired_next   = 1'b0;
                        res_entry_next   = '0;
                        state_next       = ST_DONE;
                    end
                end
            end
            ST_WR: begin
                tbl_wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (entry_hit) begin
                    res_changed_next = 1'b1;
                    res_fired_next   = 1'b1;
                    res_entry_next   = 4'(idx_reg);
                    state_next       = ST_DONE;
                end else if (idx_reg == LAST_IDX) begin
                    res_changed_next = 1'b1;
                    res_fired_next   = 1'b0;
                    res_entry_next   = '0;
                    state_next       = ST_DONE;
                end else begin
                    idx_next    = idx_reg + 1'b1;
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = {res_fired_reg, res_changed_reg};
                    m_entry_next = res_entry_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        dmask_reg       <= dmask_next;
        idx_reg         <= idx_next;
        wr_addr_reg     <= wr_addr_next;
        wr_field_reg    <= wr_field_next;
        wr_rule_reg     <= wr_rule_next;
        res_changed_reg <= res_changed_next;
        res_fired_reg   <= res_fired_next;
        res_entry_reg   <= res_entry_next;
        m_user_reg      <= m_user_next;
        m_entry_reg     <= m_entry_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {4'b0000, m_entry_reg};

    // a fire only follows a time change
    a_fire_needs_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
        else $error("fired without time change");

    // no fire means entry index zero
    a_nofire_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[3:0] == 4'd0))
        else $error("fired_entry set without fire");

    // a legal rule write goes to the merge cycle, then back to idle
    a_write_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser[0] && wr_legal) |=> (state_reg == ST_WR) ##1 (state_reg == ST_IDLE))
        else $error("rule write sequence broken");

    // scan index stays inside the table
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(idx_reg) < 32'(MAX_ENTRIES)))
        else $error("scan index out of range");

    // a changed time is recorded at acceptance
    a_prev_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tuser[0] && now_changed) |=> (prev_reg == $past(now_bits)))
        else $error("previous time not updated");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cron_schedule_matcher
// Drives rule writes and time transfers and predicts every result with a
// local copy of the schedule table and the stored time. Each result is
// compared field by field with the prediction, in order. Runs directed
// corner cases, three random phases with different idle patterns, and a
// long receiver stall that forces the block to stop taking input.
// ----------------------------------------------------------------------------
module tb;

    import csm_pkg::*;

    localparam int TIME_FIELDS   = NUM_FIELDS;
    localparam int SCHED_ENTRIES = DEF_MAX_ENTRIES;
    localparam int SETTLE_CYCLES = SCHED_ENTRIES + 4;  // longest scan plus margin
    localparam int STALL_CYCLES  = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 170;

    // transfer kinds on s_tuser
    localparam logic MODE_TIME  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // field indexes not named in the package, plus two that the block must ignore
    localparam logic [2:0] F_HOUR   = 3'd1;
    localparam logic [2:0] F_OUT_LO = 3'd5;
    localparam logic [2:0] F_OUT_HI = 3'd7;

    typedef struct packed {
        logic       time_changed;
        logic       fired;
        logic [3:0] fired_entry;
    } alarm_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // predicted state of the block
    rule_t       sched_rules [SCHED_ENTRIES][TIME_FIELDS];
    logic [5:0]  last_time [TIME_FIELDS];

    alarm_result_t pending_alarms [$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        stall_req     = 1'b0;
    logic        recv_hold     = 1'b0;
    int unsigned cycle_count   = 0;
    int          mismatch_count = 0;
    int          time_count = 0;
    int          unchanged_count = 0;
    int          write_count = 0;
    int          hit_count = 0;
    int          result_count = 0;

    cron_schedule_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_alarms.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random idling, overridden by the long stall below
    always @(posedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // one long receiver hold-off, counted here; the sender keeps offering meanwhile
    initial begin : rx_stall
        @(posedge stall_req);
        recv_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("mismatch at %0t ns: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // result checker: both signals sampled as they stood before the edge
    always @(posedge aclk) begin : check_results
        alarm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_alarms.size() == 0) begin
                report_mismatch("result with nothing pending, fired_entry", m_tdata[3:0], 0);
            end else begin
                want = pending_alarms.pop_front();
                if (m_tuser[0] !== want.time_changed)
                    report_mismatch("time_changed", m_tuser[0], want.time_changed);
                if (m_tuser[1] !== want.fired)
                    report_mismatch("fired", m_tuser[1], want.fired);
                if (m_tdata[3:0] !== want.fired_entry)
                    report_mismatch("fired_entry", m_tdata[3:0], want.fired_entry);
            end
        end
    end

    function automatic logic rule_hits(input rule_t r, input logic [5:0] v);
        case (r.kind)
            KIND_ANY:   return 1'b1;
            KIND_EXACT: return r.value == v;
            KIND_STEP:  return (r.value != '0) && ((v % r.value) == '0);
            default:    return 1'b0;
        endcase
    endfunction

    // updates the local table or stored time for one accepted transfer and
    // queues the alarm result a time transfer must produce
    task automatic predict_transfer(input logic mode, input logic [39:0] data);
        logic [5:0]    now_f [TIME_FIELDS];
        alarm_result_t res;
        logic [3:0]    ent;
        logic [2:0]    fld;
        logic          all_hit;
        ent = data[26:23];
        fld = data[29:27];
        if (mode == MODE_WRITE) begin
            write_count++;
            // every 4-bit entry index is in range; only the field index can be bad
            if (fld < TIME_FIELDS) begin
                sched_rules[ent][fld].kind  = data[31:30];
                sched_rules[ent][fld].value = data[37:32];
            end
        end else begin
            time_count++;
            now_f[0] = data[5:0];
            now_f[1] = {1'b0, data[10:6]};
            now_f[2] = {1'b0, data[15:11]};
            now_f[3] = {2'b0, data[19:16]};
            now_f[4] = {3'b0, data[22:20]};
            res = '0;
            for (int f = 0; f < TIME_FIELDS; f++)
                if (now_f[f] != last_time[f])
                    res.time_changed = 1'b1;
            if (res.time_changed) begin
                // first entry with all five rules matching wins
                for (int e = 0; e < SCHED_ENTRIES && !res.fired; e++) begin
                    all_hit = 1'b1;
                    for (int f = 0; f < TIME_FIELDS; f++)
                        if (!rule_hits(sched_rules[e][f], now_f[f]))
                            all_hit = 1'b0;
                    if (all_hit) begin
                        res.fired       = 1'b1;
                        res.fired_entry = 4'(e);
                    end
                end
                last_time = now_f;
            end else begin
                unchanged_count++;
            end
            if (res.fired)
                hit_count++;
            pending_alarms.push_back(res);
        end
    endtask

    function automatic logic [39:0] pack_item(
        input logic [5:0] mi, input logic [4:0] hr, input logic [4:0] dy,
        input logic [3:0] mo, input logic [2:0] wd, input logic [3:0] ent,
        input logic [2:0] fld, input logic [1:0] kind, input logic [5:0] val);
        return {2'b00, val, kind, fld, ent, wd, mo, dy, hr, mi};
    endfunction

    // Offers one transfer and returns at the edge that takes it. s_tvalid is
    // left high; the next call either drops it for an idle cycle or reloads it.
    task automatic send_item(input logic mode, input logic [39:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_transfer(mode, data);
    endtask

    task automatic send_time(input logic [5:0] mi, input logic [4:0] hr,
                             input logic [4:0] dy, input logic [3:0] mo,
                             input logic [2:0] wd);
        send_item(MODE_TIME, pack_item(mi, hr, dy, mo, wd, '0, '0, '0, '0));
    endtask

    task automatic send_rule(input logic [3:0] ent, input logic [2:0] fld,
                             input logic [1:0] kind, input logic [5:0] val);
        send_item(MODE_WRITE, pack_item('0, '0, '0, '0, '0, ent, fld, kind, val));
    endtask

    // drop valid, let every result come back, then let any scan settle
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_alarms.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // corner cases: reset time, empty table, all-ones time, zero and full steps,
    // ignored field indexes
    task automatic test_directed_rules();
        send_time(0, 0, 0, 0, 0);                  // equals reset time: no scan
        send_time(1, 0, 0, 0, 0);                  // table still all never
        for (int f = 0; f < TIME_FIELDS; f++)
            send_rule(4'd15, 3'(f), KIND_ANY, 6'd0);
        send_time(63, 31, 31, 15, 7);              // hits the last entry
        send_time(63, 31, 31, 15, 7);              // same time again
        send_rule(4'd15, FLD_MINUTE, KIND_STEP, 6'd0);
        send_time(0, 31, 31, 15, 7);               // zero divisor never hits
        send_rule(4'd15, FLD_MINUTE, KIND_STEP, 6'd1);
        send_time(5, 31, 31, 15, 7);
        send_rule(4'd15, FLD_WEEKDAY, KIND_EXACT, 6'd7);
        send_time(6, 31, 31, 15, 7);
        send_rule(4'd15, F_OUT_LO, KIND_NEVER, 6'd0);   // must be dropped
        send_rule(4'd15, F_OUT_HI, KIND_NEVER, 6'd63);  // must be dropped
        send_time(7, 31, 31, 15, 7);
        send_rule(4'd15, F_HOUR, KIND_NEVER, 6'd63);
        send_time(8, 31, 31, 15, 7);
        send_rule(4'd15, F_HOUR, KIND_STEP, 6'd63);
        send_time(9, 0, 31, 15, 7);                // 0 mod 63 hits
        finish_phase();
    endtask

    // Mostly plausible schedules (any, small exact values, small steps) against
    // mostly small time values so entries do fire; the rest is full-range noise.
    task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
        logic [5:0]  mi;
        logic [5:0]  val;
        logic [4:0]  hr;
        logic [4:0]  dy;
        logic [3:0]  mo;
        logic [3:0]  ent;
        logic [2:0]  wd;
        logic [2:0]  fld;
        logic [1:0]  kind;
        logic        mode;
        int unsigned pick;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < n; i++) begin
            mode = ($urandom_range(99) < 30) ? MODE_WRITE : MODE_TIME;
            if (mode == MODE_TIME && $urandom_range(99) < 15) begin
                // repeat the stored time: no scan expected
                mi = last_time[0];
                hr = last_time[1][4:0];
                dy = last_time[2][4:0];
                mo = last_time[3][3:0];
                wd = last_time[4][2:0];
            end else begin
                mi = ($urandom_range(99) < 70) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
                hr = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
                dy = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
                mo = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
                wd = ($urandom_range(99) < 70) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
            end
            ent = ($urandom_range(1) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
            fld = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            pick = $urandom_range(99);
            if (pick < 45)
                kind = KIND_ANY;
            else if (pick < 70)
                kind = KIND_EXACT;
            else if (pick < 88)
                kind = KIND_STEP;
            else
                kind = KIND_NEVER;
            if (kind == KIND_EXACT && $urandom_range(99) < 70)
                val = 6'($urandom_range(3));
            else if (kind == KIND_STEP && $urandom_range(99) < 70)
                val = 6'($urandom_range(4, 1));
            else
                val = 6'($urandom_range(63));
            send_item(mode, pack_item(mi, hr, dy, mo, wd, ent, fld, kind, val));
        end
        finish_phase();
    endtask

    // receiver holds off for a long stretch while changed times keep coming,
    // so the result slot and the scan both fill and s_tready must drop
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req <= 1'b1;
        for (int i = 0; i < 30; i++)
            send_time(6'(i + 10), 5'($urandom_range(3)), 5'($urandom_range(3)),
                      4'($urandom_range(3)), 3'($urandom_range(3)));
        finish_phase();
    endtask

    initial begin
        for (int e = 0; e < SCHED_ENTRIES; e++)
            for (int f = 0; f < TIME_FIELDS; f++)
                sched_rules[e][f] = '{kind: KIND_NEVER, value: '0};
        for (int f = 0; f < TIME_FIELDS; f++)
            last_time[f] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 79;
        test_directed_rules();
        test_random_traffic(RANDOM_ITEMS, 8, 79);
        test_random_traffic(RANDOM_ITEMS, 79, 8);
        test_random_traffic(RANDOM_ITEMS, 0, 0);
        test_backpressure();

        if (pending_alarms.size() != 0)
            report_mismatch("results never delivered", 0, pending_alarms.size());

        $display("covered %0d time transfers (%0d with no change, %0d schedule hits)",
                 time_count, unchanged_count, hit_count);
        $display("and %0d rule writes; %0d results checked, %0d mismatches",
                 write_count, result_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/csm_pkg.sv
hdl/csm_rule_mem.sv
hdl/csm_match.sv
hdl/cron_schedule_matcher.sv
bench/tb.sv
